// ===== rtl/gpe_pkg.sv =====
// ----------------------------------------------------------------------------
// gpe_pkg
// shared widths, register indexes and sequencer states of the glyph row
// pixel expander
// ----------------------------------------------------------------------------
`default_nettype none

package gpe_pkg;

   localparam int COLOR_W         = 24;
   localparam int GW_W            = 6;
   localparam int BITS_W          = 32;
   localparam int SPC_W           = 4;
   localparam int LW_W            = 12;
   localparam int CNT_W           = 6;
   localparam int CSR_IDX_W       = 2;
   localparam int MAX_GLYPH_WIDTH = 32;

   localparam logic [COLOR_W-1:0] TEXT_COLOR_RST   = {COLOR_W{1'b1}};
   localparam logic [COLOR_W-1:0] BACK_COLOR_RST   = '0;
   localparam logic [SPC_W-1:0]   CHAR_SPACING_RST = SPC_W'(1);
   localparam logic [LW_W-1:0]    LW_MAX           = {LW_W{1'b1}};
   localparam logic [GW_W-1:0]    GW_MAX           = GW_W'(MAX_GLYPH_WIDTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_COLOR   = 2'd0,
      CSR_BACK_COLOR   = 2'd1,
      CSR_CHAR_SPACING = 2'd2
   } gpe_csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MARK
   } gpe_state_type;

endpackage

`default_nettype wire

// ===== rtl/gpe_intf.sv =====
// ----------------------------------------------------------------------------
// gpe channel interfaces
// valid/ready channels for characters, pixel results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface gpe_req_if import gpe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                glyph_present;
   logic [GW_W-1:0]     glyph_width;
   logic [BITS_W-1:0]   row_bits;
   logic                last_char;

   modport source (output valid, glyph_present, glyph_width, row_bits, last_char,
                   input ready);
   modport sink   (input valid, glyph_present, glyph_width, row_bits, last_char,
                   output ready);
endinterface

interface gpe_rsp_if import gpe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COLOR_W-1:0]  pixel_color;
   logic                pixel_valid;
   logic                last_of_text;
   logic [LW_W-1:0]     line_width;

   modport source (output valid, pixel_color, pixel_valid, last_of_text, line_width,
                   input ready);
   modport sink   (input valid, pixel_color, pixel_valid, last_of_text, line_width,
                   output ready);
endinterface

interface gpe_csr_if import gpe_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COLOR_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/glyph_row_pixel_expander.sv =====
// the first result is registered in ST_EMIT or ST_MARK once the output slot
//   is free; a present glyph yields min(glyph_width, 32) + char_spacing pixels,
//   one pixel per cycle from the shifter and pixel counter unless the output stalls;
//   an absent glyph yields none, a last character with no pixels a marker result
// reset: synchronous, clears sequencer, running width and output valid;
//   registers return to white text, black background, spacing 1
// ----------------------------------------------------------------------------
// glyph_row_pixel_expander
// serializes one glyph row per character into colored pixels plus spacing,
// keeping a saturating running line width
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_pixel_expander
   import gpe_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   gpe_req_if.sink      req_ch,
   gpe_rsp_if.source    rsp_ch,
   gpe_csr_if.sink      csr_ch
);

   gpe_state_type       state_ff, state_in;
   logic [LW_W-1:0]     rw_ff, rw_in;
   logic [BITS_W-1:0]   shifter_ff, shifter_in;
   logic [CNT_W-1:0]    pix_left_ff, pix_left_in;
   logic [CNT_W-1:0]    glyph_left_ff, glyph_left_in;
   logic                last_ff, last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                pvalid_ff, pvalid_in;
   logic                plast_ff, plast_in;
   logic [LW_W-1:0]     lw_ff, lw_in;

   logic [COLOR_W-1:0]  text_color_ff;
   logic [COLOR_W-1:0]  back_color_ff;
   logic [SPC_W-1:0]    spacing_ff;

   logic                slot_free;
   logic [GW_W-1:0]     gw_sat;
   logic [CNT_W-1:0]    total;
   logic [LW_W:0]       sum;
   logic [LW_W-1:0]     rw_sat;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= TEXT_COLOR_RST;
         back_color_ff <= BACK_COLOR_RST;
         spacing_ff    <= CHAR_SPACING_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_TEXT_COLOR:   text_color_ff <= csr_ch.data;
            CSR_BACK_COLOR:   back_color_ff <= csr_ch.data;
            CSR_CHAR_SPACING: spacing_ff    <= csr_ch.data[SPC_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign slot_free           = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pixel_color  = color_ff;
   assign rsp_ch.pixel_valid  = pvalid_ff;
   assign rsp_ch.last_of_text = plast_ff;
   assign rsp_ch.line_width   = lw_ff;

   assign gw_sat = (req_ch.glyph_width > GW_MAX) ? GW_MAX : req_ch.glyph_width;
   assign total  = CNT_W'(gw_sat) + CNT_W'(spacing_ff);
   assign sum    = {1'b0, rw_ff} + (LW_W+1)'(total);
   assign rw_sat = sum[LW_W] ? LW_MAX : sum[LW_W-1:0];

   always_comb begin
      state_in      = state_ff;
      rw_in         = rw_ff;
      shifter_in    = shifter_ff;
      pix_left_in   = pix_left_ff;
      glyph_left_in = glyph_left_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      color_in      = color_ff;
      pvalid_in     = pvalid_ff;
      plast_in      = plast_ff;
      lw_in         = lw_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               last_in = req_ch.last_char;
               if (req_ch.glyph_present) begin
                  rw_in         = rw_sat;
                  shifter_in    = req_ch.row_bits;
                  glyph_left_in = CNT_W'(gw_sat);
                  pix_left_in   = total;
                  if (total != '0) begin
                     state_in = ST_EMIT;
                  end else if (req_ch.last_char) begin
                     state_in = ST_MARK;
                  end
               end else if (req_ch.last_char) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               pvalid_in    = 1'b1;
               lw_in        = rw_ff;
               plast_in     = last_ff && (pix_left_ff == CNT_W'(1));
               if (glyph_left_ff != '0) begin
                  color_in      = shifter_ff[BITS_W-1] ? text_color_ff : back_color_ff;
                  shifter_in    = {shifter_ff[BITS_W-2:0], 1'b0};
                  glyph_left_in = glyph_left_ff - CNT_W'(1);
               end else begin
                  color_in = back_color_ff;
               end
               pix_left_in = pix_left_ff - CNT_W'(1);
               if (pix_left_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
                  if (last_ff) begin
                     rw_in = '0;
                  end
               end
            end
         end
         ST_MARK: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               pvalid_in    = 1'b0;
               color_in     = '0;
               plast_in     = 1'b1;
               lw_in        = rw_ff;
               rw_in        = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rw_ff        <= '0;
         pix_left_ff  <= '0;
         glyph_left_ff <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rw_ff        <= rw_in;
         pix_left_ff  <= pix_left_in;
         glyph_left_ff <= glyph_left_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      shifter_ff <= shifter_in;
      color_ff   <= color_in;
      pvalid_ff  <= pvalid_in;
      plast_ff   <= plast_in;
      lw_ff      <= lw_in;
   end

endmodule

`default_nettype wire

// ===== rtl/gpe_checker.sv =====
// ----------------------------------------------------------------------------
// gpe_checker
// port level checks of the glyph row pixel expander, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_checker
   import gpe_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input wire                 req_glyph_present,
   input wire [GW_W-1:0]      req_glyph_width,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input wire [COLOR_W-1:0]   rsp_pixel_color,
   input wire                 rsp_pixel_valid,
   input wire                 rsp_last_of_text,
   input wire [LW_W-1:0]      rsp_line_width
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_color)
         && $stable(rsp_pixel_valid) && $stable(rsp_last_of_text)
         && $stable(rsp_line_width))
      else $error("stalled result changed");

   // a marker is black and ends the text
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |-> rsp_pixel_color == '0 && rsp_last_of_text)
      else $error("malformed marker result");

   // a drawn glyph keeps the input closed while it is serialized
   a_busy_after_glyph: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_glyph_present && req_glyph_width != '0
         |=> !req_ready)
      else $error("input open during glyph serialization");

endmodule

bind glyph_row_pixel_expander gpe_checker u_gpe_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_glyph_present (req_ch.glyph_present),
   .req_glyph_width   (req_ch.glyph_width),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_pixel_color   (rsp_ch.pixel_color),
   .rsp_pixel_valid   (rsp_ch.pixel_valid),
   .rsp_last_of_text  (rsp_ch.last_of_text),
   .rsp_line_width    (rsp_ch.line_width)
);

`default_nettype wire

// ===== bench/tb_glyph_row_pixel_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_row_pixel_expander
// drives characters through the glyph row pixel expander and checks every
// pixel, spacing pixel and text marker against an in-bench expansion of the
// glyph rows, across several color and spacing settings with random stalls
// ----------------------------------------------------------------------------

module tb_glyph_row_pixel_expander;
   import gpe_pkg::*;

   localparam int IDLE_PCT     = 17;
   localparam int SETTLE_CYC   = 4;
   localparam int END_CYC      = 50;
   localparam int RUN_LIMIT_NS = 10_000_000;

   typedef struct packed {
      logic              present;
      logic [GW_W-1:0]   width;
      logic [BITS_W-1:0] bits;
      logic              last;
   } glyph_char_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               valid;
      logic               last;
      logic [LW_W-1:0]    width;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gpe_req_if req_if ();
   gpe_rsp_if rsp_if ();
   gpe_csr_if csr_if ();

   glyph_row_pixel_expander dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   logic               req_valid = 1'b0;
   glyph_char_type     req_item  = '0;
   logic               req_fired = 1'b0;
   logic               rsp_ready = 1'b0;
   logic               csr_valid = 1'b0;
   gpe_csr_idx_type    csr_index = CSR_TEXT_COLOR;
   logic [COLOR_W-1:0] csr_data  = '0;
   logic               calm      = 1'b0;

   assign req_if.valid         = req_valid;
   assign req_if.glyph_present = req_item.present;
   assign req_if.glyph_width   = req_item.width;
   assign req_if.row_bits      = req_item.bits;
   assign req_if.last_char     = req_item.last;
   assign rsp_if.ready         = rsp_ready;
   assign csr_if.valid         = csr_valid;
   assign csr_if.index         = csr_index;
   assign csr_if.data          = csr_data;

   // predictor state and register copies
   logic [COLOR_W-1:0] ink_color   = TEXT_COLOR_RST;
   logic [COLOR_W-1:0] paper_color = BACK_COLOR_RST;
   logic [SPC_W-1:0]   gap_pixels  = CHAR_SPACING_RST;
   logic [LW_W-1:0]    line_total  = '0;

   glyph_char_type   char_q[$];
   pixel_result_type pixel_q[$];

   int chars_queued = 0;
   int chars_taken  = 0;
   int pixels_seen  = 0;
   int markers_seen = 0;
   int sat_seen     = 0;
   int reg_writes   = 0;
   int errors       = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_glyph_row_pixel_expander failed");
      $finish;
   end

   function automatic glyph_char_type glyph(logic p, int w, logic [BITS_W-1:0] b, logic l);
      glyph_char_type c;
      c.present = p;
      c.width   = GW_W'(w);
      c.bits    = b;
      c.last    = l;
      return c;
   endfunction

   function automatic glyph_char_type random_char(logic is_last);
      int w;
      if ($urandom_range(99) < 10) w = $urandom_range(63, 33);
      else w = $urandom_range(32, 0);
      return glyph($urandom_range(99) >= 10, w, $urandom, is_last);
   endfunction

   // expands one character into the pixels it should produce
   task automatic expand_glyph(input glyph_char_type c);
      int                w;
      int                n_pix;
      int                sum;
      logic [BITS_W-1:0] shifter;
      pixel_result_type  r;
      n_pix = 0;
      if (c.present) begin
         w = (int'(c.width) > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : int'(c.width);
         n_pix = w + int'(gap_pixels);
         sum = int'(line_total) + n_pix;
         line_total = (sum > int'(LW_MAX)) ? LW_MAX : LW_W'(sum);
         shifter = c.bits;
         for (int i = 0; i < n_pix; i++) begin
            if (i < w) begin
               r.color = shifter[BITS_W-1] ? ink_color : paper_color;
               shifter = shifter << 1;
            end else begin
               r.color = paper_color;
            end
            r.valid = 1'b1;
            r.last  = c.last && (i == n_pix - 1);
            r.width = line_total;
            pixel_q.push_back(r);
         end
      end
      if (c.last) begin
         if (n_pix == 0) begin
            r.color = '0;
            r.valid = 1'b0;
            r.last  = 1'b1;
            r.width = line_total;
            pixel_q.push_back(r);
         end
         line_total = '0;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (char_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_item  <= char_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= calm || $urandom_range(99) >= IDLE_PCT;
   end

   // monitor
   always @(posedge clock) begin : monitor
      pixel_result_type got;
      pixel_result_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_if.ready;
         if (rsp_if.valid && rsp_ready) begin
            got.color = rsp_if.pixel_color;
            got.valid = rsp_if.pixel_valid;
            got.last  = rsp_if.last_of_text;
            got.width = rsp_if.line_width;
            if (got.valid) pixels_seen++;
            else markers_seen++;
            if (got.width == LW_MAX) sat_seen++;
            if (pixel_q.size() == 0) begin
               errors++;
               $display("%0t unexpected result: color %h pixel %b last %b width %0d",
                        $realtime, got.color, got.valid, got.last, got.width);
            end else begin
               want = pixel_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t mismatch: expected color %h pixel %b last %b width %0d, got color %h pixel %b last %b width %0d",
                           $realtime, want.color, want.valid, want.last, want.width,
                           got.color, got.valid, got.last, got.width);
               end
            end
         end
         if (req_valid && req_if.ready) begin
            chars_taken++;
            expand_glyph(req_item);
         end
      end
   end

   task automatic push_char(input glyph_char_type c);
      char_q.push_back(c);
      chars_queued++;
   endtask

   task automatic queue_text(input int n_chars, input logic wide);
      glyph_char_type c;
      for (int k = 0; k < n_chars; k++) begin
         c = random_char(k == n_chars - 1);
         if (wide) begin
            c.present = 1'b1;
            c.width   = GW_W'($urandom_range(63, 32));
         end
         push_char(c);
      end
   endtask

   task automatic random_texts(input int n_items);
      int start;
      start = chars_queued;
      while (chars_queued - start < n_items) begin
         if ($urandom_range(99) < 8) push_char(random_char(1'($urandom_range(1))));
         else queue_text($urandom_range(12, 1), 1'b0);
      end
   endtask

   task automatic drain();
      while (chars_taken != chars_queued || pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input gpe_csr_idx_type idx, input logic [COLOR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_TEXT_COLOR: begin
            ink_color = value;
         end
         CSR_BACK_COLOR: begin
            paper_color = value;
         end
         default: begin
            gap_pixels = value[SPC_W-1:0];
         end
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // upper data bits of the spacing write are noise
   task automatic set_config(input logic [COLOR_W-1:0] ink, input logic [COLOR_W-1:0] paper,
                             input logic [SPC_W-1:0] spc);
      write_reg(CSR_TEXT_COLOR, ink);
      write_reg(CSR_BACK_COLOR, paper);
      write_reg(CSR_CHAR_SPACING, {(COLOR_W-SPC_W)'($urandom), spc});
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset settings: white on black, spacing 1
      push_char(glyph(1'b0, 8, 32'hFFFF_FFFF, 1'b0));
      push_char(glyph(1'b0, 8, 32'h0000_0000, 1'b1));
      push_char(glyph(1'b1, 0, 32'hFFFF_FFFF, 1'b0));
      push_char(glyph(1'b1, 32, 32'hFFFF_FFFF, 1'b0));
      push_char(glyph(1'b1, 32, 32'h0000_0000, 1'b0));
      push_char(glyph(1'b1, 63, 32'hA5A5_5A5A, 1'b0));
      push_char(glyph(1'b1, 33, 32'h8000_0001, 1'b0));
      push_char(glyph(1'b1, 1, 32'h8000_0000, 1'b0));
      push_char(glyph(1'b1, 1, 32'h7FFF_FFFF, 1'b0));
      push_char(glyph(1'b1, 8, 32'hFF00_0000, 1'b1));
      push_char(glyph(1'b1, 8, 32'h3C00_0000, 1'b0));
      push_char(glyph(1'b0, 16, 32'h1234_5678, 1'b1));
      drain();

      // inverted extremes, no spacing
      set_config(24'h000000, 24'hFFFFFF, 4'd0);
      push_char(glyph(1'b1, 0, 32'hFFFF_FFFF, 1'b1));
      push_char(glyph(1'b1, 5, 32'hA800_0000, 1'b1));
      push_char(glyph(1'b0, 40, 32'hFFFF_FFFF, 1'b0));
      push_char(glyph(1'b1, 0, 32'h0000_0000, 1'b0));
      push_char(glyph(1'b1, 32, 32'hC3C3_C3C3, 1'b1));
      drain();

      // widest spacing, plus a long text that pins the line width
      set_config(COLOR_W'($urandom), COLOR_W'($urandom), 4'd15);
      random_texts(90);
      queue_text(95, 1'b1);
      drain();

      // no idling on either side
      calm = 1'b1;
      set_config(COLOR_W'($urandom), COLOR_W'($urandom), SPC_W'($urandom));
      random_texts(90);
      drain();
      calm = 1'b0;

      set_config(COLOR_W'($urandom), COLOR_W'($urandom), SPC_W'($urandom));
      random_texts(90);
      drain();

      set_config(24'hFFFFFF, 24'h000000, 4'd15);
      random_texts(90);
      drain();

      repeat (END_CYC) @(posedge clock);
      if (pixel_q.size() != 0) begin
         errors++;
         $display("%0t %0d expected results never arrived", $realtime, pixel_q.size());
      end
      $display("covered %0d characters, %0d pixels, %0d text markers, %0d register writes",
               chars_taken, pixels_seen, markers_seen, reg_writes);
      $display("%0d results carried a saturated line width", sat_seen);
      if (errors == 0) begin
         $display("tb_glyph_row_pixel_expander passed");
      end else begin
         $display("tb_glyph_row_pixel_expander failed");
      end
      $finish;
   end

endmodule

// ===== glyph_row_pixel_expander.f =====
rtl/gpe_pkg.sv
rtl/gpe_intf.sv
rtl/glyph_row_pixel_expander.sv
rtl/gpe_checker.sv
bench/tb_glyph_row_pixel_expander.sv
